// ----- hdl/saa_pkg.sv -----
package saa_pkg;

    localparam int unsigned TICK_SECONDS = 2;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RULE_SEQ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REPORTS = 3'd4;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_OVER  = 2'd1;
    localparam logic [1:0] MODE_UNDER = 2'd2;
    localparam logic [1:0] MODE_CROSS = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_DONE = 1'b1;

    localparam logic [16:0] PERSIST_MAX = 17'h1FFFF;
    localparam logic [8:0]  SENT_MAX    = 9'd256;

    typedef struct packed {
        logic        cmd;
        logic [15:0] speed_sample;
        logic        send_ok;
    } saa_in_t;

    typedef struct packed {
        logic        report_request;
        logic        alarm_armed;
        logic [15:0] report_rule_seq;
        logic [8:0]  reports_done;
    } saa_out_t;

    typedef struct packed {
        logic [15:0] rule_seq;
        logic [1:0]  rule_mode;
        logic [15:0] speed_limit;
        logic [15:0] interval_seconds;
        logic [7:0]  max_reports;
    } saa_cfg_t;

endpackage

// ----- hdl/saa_cfg_regs.sv -----
module saa_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [saa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [saa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output saa_pkg::saa_cfg_t                 cfg
);

    saa_pkg::saa_cfg_t cfg_reg;
    saa_pkg::saa_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                saa_pkg::REG_RULE_SEQ:    cfg_next.rule_seq         = cfg_data;
                saa_pkg::REG_RULE_MODE:   cfg_next.rule_mode        = cfg_data[1:0];
                saa_pkg::REG_SPEED_LIMIT: cfg_next.speed_limit      = cfg_data;
                saa_pkg::REG_INTERVAL:    cfg_next.interval_seconds = cfg_data;
                saa_pkg::REG_MAX_REPORTS: cfg_next.max_reports      = cfg_data[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/saa_engine.sv -----
module saa_engine
#(
    parameter int unsigned TICK_SECONDS = saa_pkg::TICK_SECONDS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  saa_pkg::saa_cfg_t   cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  saa_pkg::saa_in_t    item,
    output logic                result_valid,
    input  logic                result_ready,
    output saa_pkg::saa_out_t   result
);

    // input stage
    saa_pkg::saa_in_t  item_reg;
    logic              item_vld_reg;
    logic              item_vld_next;

    // result stage
    saa_pkg::saa_out_t res_reg;
    saa_pkg::saa_out_t res_next;
    logic              res_vld_reg;
    logic              res_vld_next;

    // monitor state
    logic [31:0] clock_reg,   clock_next;
    logic [15:0] prev_reg,    prev_next;
    logic [16:0] persist_reg, persist_next;
    logic        armed_reg,   armed_next;
    logic [8:0]  sent_reg,    sent_next;
    logic [31:0] last_reg,    last_next;
    logic [15:0] seen_reg,    seen_next;
    logic        pend_reg,    pend_next;

    logic        advance;
    logic        req;
    logic        err;
    logic        spd_gt;
    logic        spd_lt;
    logic        prev_gt;
    logic        prev_lt;
    logic [17:0] persist_sum;
    logic [9:0]  sent_sum;
    logic [31:0] elapsed;

    assign advance      = item_vld_reg && (!res_vld_reg || result_ready);
    assign item_ready   = !item_vld_reg || advance;
    assign item_vld_next = (item_valid && item_ready) || (item_vld_reg && !advance);
    assign res_vld_next = advance || (res_vld_reg && !result_ready);

    assign spd_gt  = item_reg.speed_sample > cfg.speed_limit;
    assign spd_lt  = item_reg.speed_sample < cfg.speed_limit;
    assign prev_gt = prev_reg > cfg.speed_limit;
    assign prev_lt = prev_reg < cfg.speed_limit;

    assign persist_sum = {1'b0, persist_reg} + 18'(TICK_SECONDS);
    assign sent_sum    = {1'b0, sent_reg} + {9'd0, item_reg.send_ok};
    assign elapsed     = clock_reg - last_reg;

    always_comb
    begin
        case (cfg.rule_mode)
            saa_pkg::MODE_OVER:  err = spd_gt;
            saa_pkg::MODE_UNDER: err = spd_lt;
            saa_pkg::MODE_CROSS: err = (spd_gt && prev_lt) || (spd_lt && prev_gt);
            default:             err = 1'b0;
        endcase
    end

    always_comb
    begin
        clock_next   = clock_reg;
        prev_next    = prev_reg;
        persist_next = persist_reg;
        armed_next   = armed_reg;
        sent_next    = sent_reg;
        last_next    = last_reg;
        seen_next    = seen_reg;
        pend_next    = pend_reg;
        req          = 1'b0;

        if (item_reg.cmd == saa_pkg::CMD_DONE)
        begin
            sent_next = (sent_sum > {1'b0, saa_pkg::SENT_MAX}) ? saa_pkg::SENT_MAX
                                                              : sent_sum[8:0];
            pend_next = 1'b0;
        end
        else
        begin
            clock_next = clock_reg + 32'(TICK_SECONDS);
            if (!pend_reg && !armed_reg)
            begin
                if (cfg.rule_seq != seen_reg || cfg.rule_seq == 16'd0)
                begin
                    // restart the monitor on a new rule or while rule_seq is zero
                    armed_next   = 1'b0;
                    sent_next    = '0;
                    persist_next = '0;
                    last_next    = '0;
                    seen_next    = cfg.rule_seq;
                end
                else
                begin
                    prev_next = item_reg.speed_sample;
                    if (!err)
                    begin
                        persist_next = '0;
                    end
                    else if (cfg.rule_mode == saa_pkg::MODE_CROSS)
                    begin
                        armed_next = 1'b1;
                        sent_next  = '0;
                    end
                    else
                    begin
                        persist_next = (persist_sum > {1'b0, saa_pkg::PERSIST_MAX})
                                       ? saa_pkg::PERSIST_MAX : persist_sum[16:0];
                        if (persist_next >= {1'b0, cfg.interval_seconds})
                        begin
                            armed_next = 1'b1;
                            sent_next  = '0;
                        end
                    end
                end
            end
            else if (!pend_reg)
            begin
                if (sent_reg > {1'b0, cfg.max_reports})
                begin
                    armed_next = 1'b0;
                    sent_next  = '0;
                end
                else if (elapsed > {16'd0, cfg.interval_seconds})
                begin
                    last_next = clock_reg;
                    pend_next = 1'b1;
                    req       = 1'b1;
                end
            end
        end

        res_next.report_request  = req;
        res_next.alarm_armed     = armed_next;
        res_next.report_rule_seq = seen_next;
        res_next.reports_done    = sent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            clock_reg    <= '0;
            prev_reg     <= '0;
            persist_reg  <= '0;
            armed_reg    <= 1'b0;
            sent_reg     <= '0;
            last_reg     <= '0;
            seen_reg     <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
            if (advance)
            begin
                clock_reg   <= clock_next;
                prev_reg    <= prev_next;
                persist_reg <= persist_next;
                armed_reg   <= armed_next;
                sent_reg    <= sent_next;
                last_reg    <= last_next;
                seen_reg    <= seen_next;
                pend_reg    <= pend_next;
            end
        end
    end

    // payload stages carry no reset
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

// ----- hdl/speed_anomaly_alarm_core.sv -----
// A word accepted into the input register moves on to the result register
// when that is free. Throughput: one word per cycle while result_ready is high;
// the monitor state updates in a single pass.
// Reset (rst_n, async, active low) clears configuration, monitor state and
// both stage valid flags; the block accepts a word in the first cycle after.
module speed_anomaly_alarm_core
#(
    parameter int unsigned TICK_SECONDS = saa_pkg::TICK_SECONDS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [saa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [saa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  saa_pkg::saa_in_t                  item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output saa_pkg::saa_out_t                 result
);

    saa_pkg::saa_cfg_t cfg;

    saa_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    saa_engine
    #(
        .TICK_SECONDS (TICK_SECONDS)
    )
    u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- hdl/saa_check.sv -----
module saa_check
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  logic                result_valid,
    input  logic                result_ready,
    input  saa_pkg::saa_out_t   result
);

    // hold a stalled result word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // a new result follows an accepted word through the input and result registers
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without an accepted word");

    // an empty result stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty result stage");

    a_request_armed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.report_request |-> result.alarm_armed)
        else $error("report requested while not armed");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.reports_done <= saa_pkg::SENT_MAX)
        else $error("report count beyond saturation");

endmodule

bind speed_anomaly_alarm_core saa_check u_saa_check (.*);
